// ===== rtl/wcmt_pkg.sv =====
// shared types and constants for the worker clock minimum tracker
// no dependencies; imported by every module of the block
`default_nettype none

package wcmt_pkg;

	localparam int CLK_W = 31;
	localparam int NUM_WORKERS_DEF = 64;
	localparam logic [CLK_W-1:0] CLOCK_MAX = {CLK_W{1'b1}};
	localparam logic signed [CLK_W:0] MIN_UNSET = -32'sd1;

	typedef enum logic [1:0] {
		KIND_ADD   = 2'd0,
		KIND_TICK  = 2'd1,
		KIND_UNTIL = 2'd2,
		KIND_READ  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LOAD,
		ST_CLAMP,
		ST_GAP,
		ST_CATCH,
		ST_ADV,
		ST_DONE
	} state_t;

	// partial result handed from cell to cell during a scan
	typedef struct packed {
		logic             shared;
		logic             has_next;
		logic [CLK_W-1:0] next_clk;
		logic             wpres;
		logic [CLK_W-1:0] wclk;
	} scan_t;

	// current minimum as seen by the cells
	typedef struct packed {
		logic             mset;
		logic [CLK_W-1:0] m;
	} bcast_t;

	// write into the addressed cell
	typedef struct packed {
		logic             en;
		logic [CLK_W-1:0] clk_val;
	} wr_t;

	localparam scan_t SCAN_INIT = '{shared: 1'b0, has_next: 1'b0, next_clk: '0,
		wpres: 1'b0, wclk: '0};

endpackage

`default_nettype wire

// ===== rtl/wcmt_cell.sv =====
// one worker slot: clock and present bit, plus one step of the scan chain
// depends on wcmt_pkg
`default_nettype none

module wcmt_cell #(
	parameter int IDX_W = 6,
	parameter int INDEX = 0
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire  [IDX_W-1:0]      w,
	input  wcmt_pkg::bcast_t      bc,
	input  wcmt_pkg::wr_t         wr,
	input  wire  [IDX_W-1:0]      wr_idx,
	input  wcmt_pkg::scan_t       scan_in,
	output wcmt_pkg::scan_t       scan_out
);
	import wcmt_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic [CLK_W-1:0] clk_q;
	logic             pres_q;
	scan_t            scan_q;
	scan_t            scan_d;
	logic             self;
	logic             other;
	logic             gtm;

	assign self  = (w == MY_IDX);
	assign other = pres_q && !self;
	assign gtm   = other && (clk_q > bc.m);

	always_comb begin
		scan_d = scan_in;
		if (other && bc.mset && clk_q == bc.m) begin
			scan_d.shared = 1'b1;
		end
		// smallest clock strictly above the minimum among the other workers
		if (gtm && (!scan_in.has_next || clk_q < scan_in.next_clk)) begin
			scan_d.has_next = 1'b1;
			scan_d.next_clk = clk_q;
		end
		if (self) begin
			scan_d.wpres = pres_q;
			scan_d.wclk  = clk_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pres_q <= 1'b0;
		end else if (wr.en && wr_idx == MY_IDX) begin
			pres_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr_idx == MY_IDX) begin
			clk_q <= wr.clk_val;
		end
		scan_q <= scan_d;
	end

	assign scan_out = scan_q;

endmodule

`default_nettype wire

// ===== rtl/wcmt_ctrl.sv =====
// sequencer: takes a transaction, runs the cell scan, does the tick arithmetic,
// writes the cell back and holds the result; depends on wcmt_pkg
`default_nettype none

module wcmt_ctrl #(
	parameter int NUM_WORKERS = wcmt_pkg::NUM_WORKERS_DEF,
	parameter int IDX_W = $clog2(NUM_WORKERS)
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 s_axis_tvalid,
	output logic                s_axis_tready,
	input  wire  [39:0]         s_axis_tdata,
	input  wire  [1:0]          s_axis_tuser,
	output logic                m_axis_tvalid,
	input  wire                 m_axis_tready,
	output logic [95:0]         m_axis_tdata,
	output logic [0:0]          m_axis_tuser,
	output logic [IDX_W-1:0]    w,
	output wcmt_pkg::bcast_t    bc,
	output wcmt_pkg::wr_t       wr,
	input  wcmt_pkg::scan_t     scan_tail
);
	import wcmt_pkg::*;

	localparam int CNT_W = $clog2(NUM_WORKERS + 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_WORKERS - 1);

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	kind_t               kind_q;
	logic [IDX_W-1:0]    widx_q;
	logic [CLK_W-1:0]    val_q;
	logic                oor_q;
	logic signed [31:0]  min_q;

	logic                pres_q;
	logic                shared_q;
	logic                hn_q;
	logic [CLK_W-1:0]    next_q;
	logic [CLK_W-1:0]    c_q;
	logic signed [31:0]  n_q;
	logic [CLK_W-1:0]    room_q;
	logic signed [31:0]  gap_q;
	logic [CLK_W-1:0]    k_q;
	logic [CLK_W-1:0]    adv_q;

	logic                o_valid_q;
	logic signed [31:0]  o_min_q;
	logic [CLK_W-1:0]    o_adv_q;
	logic [CLK_W-1:0]    o_wclk_q;
	logic                o_absent_q;

	logic                accept;
	logic                out_free;
	logic                finish;
	logic [1:0]          in_kind;
	logic [5:0]          in_worker;
	logic [CLK_W-1:0]    in_val;
	logic                mset;
	logic [CLK_W-1:0]    c_load;
	logic [31:0]         nx;
	logic [31:0]         cand;
	logic                adv_ok;
	logic signed [31:0]  min_add;
	logic signed [31:0]  min_tick;

	assign in_kind   = s_axis_tuser;
	assign in_worker = s_axis_tdata[5:0];
	assign in_val    = s_axis_tdata[36:6];

	assign mset      = !min_q[31];
	assign accept    = s_axis_tvalid && s_axis_tready;
	assign out_free  = !o_valid_q || m_axis_tready;
	assign finish    = (state_q == ST_DONE) && out_free;

	assign w  = widx_q;
	assign bc = '{mset: mset, m: min_q[CLK_W-1:0]};

	assign c_load   = scan_tail.wpres ? scan_tail.wclk : '0;
	assign nx       = hn_q ? {1'b0, next_q} : 32'h8000_0000;
	assign cand     = nx - {1'b0, min_q[CLK_W-1:0]};
	assign adv_ok   = (n_q != 0) && mset && (c_q == min_q[CLK_W-1:0]) && !shared_q;
	assign min_add  = (!mset || val_q < min_q[CLK_W-1:0]) ? $signed({1'b0, val_q}) : min_q;
	assign min_tick = min_q + $signed({1'b0, adv_q});

	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		s_axis_tready = 1'b0;
		wr            = '{en: 1'b0, clk_val: c_q};
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				cnt_d = '0;
				if (s_axis_tvalid) begin
					state_d = (int'(in_worker) < NUM_WORKERS) ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_d = (kind_q == KIND_TICK || kind_q == KIND_UNTIL) ? ST_CLAMP : ST_DONE;
			end
			ST_CLAMP: state_d = ST_GAP;
			ST_GAP:   state_d = ST_CATCH;
			ST_CATCH: state_d = ST_ADV;
			ST_ADV:   state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
					if (!oor_q && kind_q != KIND_READ) begin
						wr.en = 1'b1;
						wr.clk_val = (kind_q == KIND_ADD) ? val_q : c_q;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			min_q     <= MIN_UNSET;
			o_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (finish) begin
				o_valid_q <= 1'b1;
				if (!oor_q && kind_q == KIND_ADD) begin
					min_q <= min_add;
				end else if (!oor_q && (kind_q == KIND_TICK || kind_q == KIND_UNTIL)) begin
					min_q <= min_tick;
				end
			end else if (m_axis_tready) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					kind_q <= kind_t'(in_kind);
					widx_q <= IDX_W'(in_worker);
					val_q  <= in_val;
					oor_q  <= !(int'(in_worker) < NUM_WORKERS);
				end
			end
			ST_LOAD: begin
				pres_q   <= scan_tail.wpres;
				shared_q <= scan_tail.shared;
				hn_q     <= scan_tail.has_next;
				next_q   <= scan_tail.next_clk;
				c_q      <= c_load;
				room_q   <= ~c_load;
				n_q      <= (kind_q == KIND_TICK) ? 32'sd1 :
					$signed({1'b0, val_q}) - $signed({1'b0, c_load});
			end
			ST_CLAMP: begin
				// no ticks for a non-positive distance, none past the largest clock
				if (n_q <= 0) begin
					n_q <= '0;
				end else if ($signed({1'b0, room_q}) < n_q) begin
					n_q <= $signed({1'b0, room_q});
				end
				gap_q <= $signed({1'b0, min_q[CLK_W-1:0]}) - $signed({1'b0, c_q});
			end
			ST_GAP: begin
				// a worker below the minimum first catches up to it
				if (mset && gap_q > 0 && n_q != 0) begin
					k_q <= (gap_q < n_q) ? gap_q[CLK_W-1:0] : n_q[CLK_W-1:0];
				end else begin
					k_q <= '0;
				end
			end
			ST_CATCH: begin
				c_q <= c_q + k_q;
				n_q <= n_q - $signed({1'b0, k_q});
			end
			ST_ADV: begin
				if (adv_ok) begin
					adv_q <= (cand < 32'(n_q)) ? cand[CLK_W-1:0] : n_q[CLK_W-1:0];
				end else begin
					adv_q <= '0;
				end
				c_q <= c_q + n_q[CLK_W-1:0];
			end
			default: ;
		endcase

		if (finish) begin
			if (oor_q) begin
				o_min_q    <= min_q;
				o_adv_q    <= '0;
				o_wclk_q   <= '0;
				o_absent_q <= 1'b1;
			end else begin
				case (kind_q)
					KIND_ADD: begin
						o_min_q    <= min_add;
						o_adv_q    <= '0;
						o_wclk_q   <= val_q;
						o_absent_q <= 1'b0;
					end
					KIND_READ: begin
						o_min_q    <= min_q;
						o_adv_q    <= '0;
						o_wclk_q   <= c_q;
						o_absent_q <= !pres_q;
					end
					default: begin
						o_min_q    <= min_tick;
						o_adv_q    <= (adv_q != '0) ? min_tick[CLK_W-1:0] : '0;
						o_wclk_q   <= c_q;
						o_absent_q <= 1'b0;
					end
				endcase
			end
		end
	end

	assign m_axis_tvalid = o_valid_q;
	assign m_axis_tdata  = {2'b00, o_wclk_q, o_adv_q, o_min_q};
	assign m_axis_tuser  = o_absent_q;

	a_min_held_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |=> $stable(min_q))
		else $error("minimum changed with no transaction in progress");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> !wr.en)
		else $error("cell written while a scan runs");

	a_scan_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> cnt_q <= CNT_LAST)
		else $error("scan counter ran past the last cell");

	a_adv_is_min: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid_q && o_adv_q != '0 |-> o_min_q == $signed({1'b0, o_adv_q}))
		else $error("reported raised minimum differs from the minimum");

endmodule

`default_nettype wire

// ===== rtl/worker_clock_min_tracker_unit.sv =====
// channel   dir  signals                    contents (lowest bit first)
// op in     in   s_axis_tvalid/tready       tdata: worker[5:0] clock_value[36:6]
//                                           tuser: kind[1:0]
// result    out  m_axis_tvalid/tready       tdata: min_clock[31:0] advanced_min[62:32]
//                                           worker_clock[93:63]; tuser: absent[0]
// one transaction at a time: an in-range op scans every cell, one per cycle,
// then loads; add and read then finish, tick ops first pass the clamp, gap,
// catch and advance steps; an op on an index not below NUM_WORKERS skips the scan
// reset clears the present bits and sets the minimum to unset; no clearing pass
// the next op is taken while a result waits; a stalled result holds the sequencer
// top level: scan chain of worker cells plus the sequencer; depends on wcmt_pkg,
// wcmt_cell and wcmt_ctrl
`default_nettype none

module worker_clock_min_tracker_unit #(
	parameter int NUM_WORKERS = wcmt_pkg::NUM_WORKERS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [39:0] s_axis_tdata,  // worker, clock_value
	input  wire  [1:0]  s_axis_tuser,  // kind
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [95:0] m_axis_tdata,  // min_clock, advanced_min, worker_clock
	output logic [0:0]  m_axis_tuser   // absent
);
	import wcmt_pkg::*;

	localparam int IDX_W = $clog2(NUM_WORKERS);

	logic [IDX_W-1:0] w;
	bcast_t           bc;
	wr_t              wr;
	scan_t            chain [NUM_WORKERS+1];

	assign chain[0] = SCAN_INIT;

	for (genvar i = 0; i < NUM_WORKERS; i++) begin : g_cell
		wcmt_cell #(
			.IDX_W (IDX_W),
			.INDEX (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.w        (w),
			.bc       (bc),
			.wr       (wr),
			.wr_idx   (w),
			.scan_in  (chain[i]),
			.scan_out (chain[i+1])
		);
	end

	wcmt_ctrl #(
		.NUM_WORKERS (NUM_WORKERS),
		.IDX_W       (IDX_W)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.w             (w),
		.bc            (bc),
		.wr            (wr),
		.scan_tail     (chain[NUM_WORKERS])
	);

endmodule

`default_nettype wire

// ===== tb/min_tracker_checker.sv =====
// result checker for the worker clock minimum tracker: keeps its own copy of the worker
// clocks, present bits and global minimum, predicts one result per op and compares
// depends on wcmt_pkg for the op kinds and the clock limit
`default_nettype none

module min_tracker_checker #(
	parameter int NUM_WORKERS = wcmt_pkg::NUM_WORKERS_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                op_valid,
	input  wire                op_ready,
	input  wire         [39:0] op_data,   // worker, clock_value
	input  wire         [1:0]  op_user,   // kind
	input  wire                res_valid,
	input  wire                res_ready,
	input  wire         [95:0] res_data,  // min_clock, advanced_min, worker_clock
	input  wire         [0:0]  res_user,  // absent
	output int                 fail_count,
	output int                 outstanding,
	output int                 results_checked,
	output int                 min_raises,
	output logic signed [31:0] tracked_min
);

	import wcmt_pkg::*;

	typedef struct packed {
		logic signed [31:0] min_clock;
		logic [30:0]        advanced_min;
		logic [30:0]        worker_clock;
		logic               absent;
	} result_t;

	localparam longint CLK_TOP = longint'(CLOCK_MAX);

	longint  slot_clock [NUM_WORKERS];
	bit      slot_present [NUM_WORKERS];
	longint  floor_clock;
	result_t due_results [$];
	int      n_bad;
	int      n_checked;
	int      n_raised;

	// applies up to n_ticks ticks to a present worker, returns the last minimum raised or 0
	function automatic longint advance_slot(input int w, input longint n_ticks);
		longint c, m, raised, k, nxt, step;
		bit     shared;
		c = slot_clock[w];
		m = floor_clock;
		raised = 0;
		if (n_ticks > CLK_TOP - c)
			n_ticks = CLK_TOP - c;
		// a worker below the minimum first climbs up to it
		if (m >= 0 && c < m && n_ticks > 0) begin
			k = m - c;
			if (k > n_ticks)
				k = n_ticks;
			c += k;
			n_ticks -= k;
		end
		if (n_ticks > 0 && c == m) begin
			shared = 1'b0;
			nxt = CLK_TOP + 1;
			for (int i = 0; i < NUM_WORKERS; i++) begin
				if (i != w && slot_present[i]) begin
					if (slot_clock[i] == m)
						shared = 1'b1;
					else if (slot_clock[i] > m && slot_clock[i] < nxt)
						nxt = slot_clock[i];
				end
			end
			// sole holder drags the minimum along until the next worker up
			if (!shared) begin
				step = nxt - m;
				if (step > n_ticks)
					step = n_ticks;
				c += step;
				m += step;
				n_ticks -= step;
				if (step > 0)
					raised = m;
			end
		end
		c += n_ticks;
		slot_clock[w] = c;
		floor_clock = m;
		return raised;
	endfunction

	function automatic result_t predict_op(input kind_t k, input int w, input longint v);
		result_t r;
		longint  raised, n_ticks;
		raised = 0;
		r.worker_clock = '0;
		r.absent = 1'b0;
		if (w >= NUM_WORKERS) begin
			r.absent = 1'b1;
		end else begin
			case (k)
				KIND_ADD: begin
					slot_clock[w] = v;
					slot_present[w] = 1'b1;
					if (floor_clock == -1 || v < floor_clock)
						floor_clock = v;
					r.worker_clock = 31'(v);
				end
				KIND_TICK, KIND_UNTIL: begin
					if (!slot_present[w]) begin
						slot_present[w] = 1'b1;
						slot_clock[w] = 0;
					end
					n_ticks = (k == KIND_TICK) ? 1 : v - slot_clock[w];
					if (n_ticks > 0)
						raised = advance_slot(w, n_ticks);
					r.worker_clock = 31'(slot_clock[w]);
				end
				default: begin
					if (slot_present[w])
						r.worker_clock = 31'(slot_clock[w]);
					else
						r.absent = 1'b1;
				end
			endcase
		end
		r.min_clock = 32'(floor_clock);
		r.advanced_min = 31'(raised);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		result_t got, want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_WORKERS; i++) begin
				slot_clock[i] = 0;
				slot_present[i] = 1'b0;
			end
			floor_clock = -1;
			due_results.delete();
			n_bad = 0;
			n_checked = 0;
			n_raised = 0;
			fail_count <= 0;
			outstanding <= 0;
			results_checked <= 0;
			min_raises <= 0;
			tracked_min <= -32'sd1;
		end else begin
			// result side first: a result always belongs to an earlier op
			if (res_valid && res_ready) begin
				got.min_clock = res_data[31:0];
				got.advanced_min = res_data[62:32];
				got.worker_clock = res_data[93:63];
				got.absent = res_user[0];
				n_checked++;
				if (due_results.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display("result %0d arrived with none due: min %0d adv %0d clk %0d absent %0b",
							n_checked, got.min_clock, got.advanced_min, got.worker_clock,
							got.absent);
				end else begin
					want = due_results.pop_front();
					if (got !== want) begin
						n_bad++;
						if (n_bad <= 10)
							$display("result %0d wrong (expected/actual): min %0d/%0d adv %0d/%0d clk %0d/%0d absent %0b/%0b",
								n_checked, want.min_clock, got.min_clock, want.advanced_min,
								got.advanced_min, want.worker_clock, got.worker_clock,
								want.absent, got.absent);
					end
				end
			end
			if (op_valid && op_ready) begin
				want = predict_op(kind_t'(op_user), int'(op_data[5:0]), longint'(op_data[36:6]));
				if (want.advanced_min != 0)
					n_raised++;
				due_results.push_back(want);
			end
			fail_count <= n_bad;
			outstanding <= due_results.size();
			results_checked <= n_checked;
			min_raises <= n_raised;
			tracked_min <= 32'(floor_clock);
		end
	end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// top of the worker clock minimum tracker testbench: clock, reset, op stimulus,
// result back-pressure and the verdict; checking is left to min_tracker_checker
// depends on wcmt_pkg, worker_clock_min_tracker_unit and min_tracker_checker
`default_nettype none

module tb;

	import wcmt_pkg::*;

	localparam int NUM_WORKERS = NUM_WORKERS_DEF;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int SEGMENTS = 35;
	localparam int SEG_OPS = 50;
	localparam longint CLK_TOP = longint'(CLOCK_MAX);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic [39:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tready = 1'b0;
	wire s_tready;
	wire m_tvalid;
	wire [95:0] m_tdata;
	wire [0:0] m_tuser;

	int fail_count, outstanding, results_checked, min_raises;
	logic signed [31:0] tracked_min;

	int kind_seen [4] = '{0, 0, 0, 0};
	int gap_odds = 0;
	int stall_odds = 0;
	int cycle_count = 0;

	always #5 clk = ~clk;

	worker_clock_min_tracker_unit #(.NUM_WORKERS(NUM_WORKERS)) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tuser  (m_tuser)
	);

	min_tracker_checker #(.NUM_WORKERS(NUM_WORKERS)) u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.op_valid        (s_tvalid),
		.op_ready        (s_tready),
		.op_data         (s_tdata),
		.op_user         (s_tuser),
		.res_valid       (m_tvalid),
		.res_ready       (m_tready),
		.res_data        (m_tdata),
		.res_user        (m_tuser),
		.fail_count      (fail_count),
		.outstanding     (outstanding),
		.results_checked (results_checked),
		.min_raises      (min_raises),
		.tracked_min     (tracked_min)
	);

	task automatic issue_op(input kind_t k, input int w, input longint v);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, 31'(v), 6'(w)};
		s_tuser <= k;
		do @(posedge clk); while (!s_tready);
		kind_seen[k]++;
	endtask

	task automatic pause_ops(input int n);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// hold the op side until the block has handed back everything owed
	task automatic drain_results();
		pause_ops(1);
		while (outstanding != 0) @(posedge clk);
	endtask

	// mostly ops on a small pool of workers with clocks close to the tracked minimum,
	// so ties, sole holders and stale minimums keep coming up; the rest is wide noise
	task automatic random_op(input bit focused, input int pool_base, input int pool_sz);
		kind_t  k;
		int     w, pick;
		longint anchor, v;
		if (focused) begin
			w = (pool_base + $urandom_range(0, pool_sz - 1)) % NUM_WORKERS;
			pick = $urandom_range(0, 99);
			k = pick < 25 ? KIND_ADD : pick < 60 ? KIND_TICK : pick < 85 ? KIND_UNTIL : KIND_READ;
			anchor = (tracked_min < 0) ? 0 : longint'(tracked_min);
			if (k == KIND_ADD && $urandom_range(0, 3) == 0)
				v = anchor - int'($urandom_range(0, 4));
			else if (k == KIND_ADD)
				v = anchor + int'($urandom_range(0, 6));
			else
				v = anchor + int'($urandom_range(0, 14)) - 2;
			if (v < 0)
				v = 0;
			if (v > CLK_TOP)
				v = CLK_TOP;
		end else begin
			k = kind_t'($urandom_range(0, 3));
			w = $urandom_range(0, 63);
			if ($urandom_range(0, 2) == 0)
				v = CLK_TOP - int'($urandom_range(0, 3));
			else
				v = longint'($urandom & 32'h7fff_ffff);
		end
		issue_op(k, w, v);
		if (gap_odds != 0 && $urandom_range(0, gap_odds) == 0)
			pause_ops($urandom_range(1, 19));
	endtask

	// result side back-pressure in bursts
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (stall_odds != 0 && $urandom_range(0, stall_odds) == 0) begin
				stall_left = $urandom_range(1, 19) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("no progress after %0d cycles, %0d results still due", cycle_count, outstanding);
		$display("simulation failed");
		$finish;
	end

	initial begin : stimulus
		int  pool_base, pool_sz, pick;
		bit  all_noise;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		stall_odds = 6;
		// empty tracker: read of an absent worker, ticks that insert workers with no minimum set
		issue_op(KIND_READ, 5, 0);
		issue_op(KIND_TICK, 63, CLK_TOP);
		issue_op(KIND_UNTIL, 62, 0);
		// saturation at the top of the clock range
		issue_op(KIND_ADD, 0, CLK_TOP - 2);
		issue_op(KIND_ADD, 1, CLK_TOP);
		pause_ops(7);
		issue_op(KIND_TICK, 0, 0);
		issue_op(KIND_UNTIL, 0, CLK_TOP);
		issue_op(KIND_TICK, 0, 0);
		issue_op(KIND_TICK, 1, 0);
		issue_op(KIND_READ, 0, 0);
		issue_op(KIND_READ, 63, 0);
		// shared minimum, sole holder, non-positive distance
		issue_op(KIND_ADD, 2, 10);
		issue_op(KIND_ADD, 3, 10);
		issue_op(KIND_TICK, 2, 0);
		issue_op(KIND_TICK, 3, 0);
		pause_ops(19);
		issue_op(KIND_UNTIL, 2, 5);
		issue_op(KIND_UNTIL, 3, 20);
		issue_op(KIND_TICK, 2, 0);
		issue_op(KIND_UNTIL, 2, 100);
		// stale minimum, then a fresh worker climbing from below
		issue_op(KIND_ADD, 3, 50);
		issue_op(KIND_TICK, 4, 0);
		issue_op(KIND_UNTIL, 4, 30);
		issue_op(KIND_ADD, 5, 0);
		issue_op(KIND_READ, 5, 0);
		issue_op(KIND_READ, 6, 0);
		drain_results();

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			if (seg >= SEGMENTS - 3) begin
				gap_odds = 0;
				stall_odds = 0;
			end else begin
				pick = $urandom_range(0, 3);
				gap_odds = pick == 0 ? 0 : pick == 1 ? 3 : pick == 2 ? 12 : 40;
				pick = $urandom_range(0, 3);
				stall_odds = pick == 0 ? 0 : pick == 1 ? 2 : pick == 2 ? 10 : 40;
			end
			pool_base = $urandom_range(0, 63);
			pool_sz = $urandom_range(2, 6);
			all_noise = ($urandom_range(0, 5) == 0);
			for (int i = 0; i < SEG_OPS; i++)
				random_op(!all_noise && $urandom_range(0, 3) != 0, pool_base, pool_sz);
			if (seg % 10 == 0)
				drain_results();
		end

		pause_ops(1);
		while (outstanding != 0) @(posedge clk);
		repeat (NUM_WORKERS + 16) @(posedge clk);
		$display("covered %0d add, %0d tick, %0d tick-until and %0d read ops",
			kind_seen[KIND_ADD], kind_seen[KIND_TICK], kind_seen[KIND_UNTIL], kind_seen[KIND_READ]);
		$display("%0d results checked, %0d of them raised the minimum, %0d mismatches",
			results_checked, min_raises, fail_count);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/wcmt_pkg.sv
rtl/wcmt_cell.sv
rtl/wcmt_ctrl.sv
rtl/worker_clock_min_tracker_unit.sv
tb/min_tracker_checker.sv
tb/tb.sv
